// ----- src/dvrt_pkg.sv -----
// ----------------------------------------------------------------------------
// dvrt_pkg: shared types and constants of the distance-vector route table
// Route entry layout and result status codes.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int unsigned AddrW = 8;
  localparam int unsigned HopsW = 8;

  typedef struct packed {
    logic [AddrW-1:0] destination;
    logic [AddrW-1:0] gateway;
    logic [HopsW-1:0] hops;
  } entry_t;

  typedef logic [2:0] status_t;

  localparam status_t ST_OWN       = 3'd0;
  localparam status_t ST_INSERTED  = 3'd1;
  localparam status_t ST_IMPROVED  = 3'd2;
  localparam status_t ST_UNCHANGED = 3'd3;
  localparam status_t ST_FULL      = 3'd4;
  localparam status_t ST_FOUND     = 3'd5;
  localparam status_t ST_SELF      = 3'd6;
  localparam status_t ST_NO_ROUTE  = 3'd7;

  localparam logic [HopsW-1:0] HOPS_MAX = {HopsW{1'b1}};

endpackage

// ----- src/dvrt_store.sv -----
// ----------------------------------------------------------------------------
// dvrt_store: route entry memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dvrt_store
  import dvrt_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  entry_t        wr_entry,
  input  logic [AW-1:0] rd_addr,
  output entry_t        rd_entry
);

  entry_t mem [DEPTH];
  entry_t rd_entry_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    rd_entry_r <= mem[rd_addr];
  end

  assign rd_entry = rd_entry_r;

endmodule

// ----- src/distance_vector_route_table.sv -----
// ----------------------------------------------------------------------------
// distance_vector_route_table: distance-vector routing table
// Holds up to TABLE_DEPTH routes and serves advertisements and lookups.
// ----------------------------------------------------------------------------
// Usage:
//   Present a command word on in_* with start high; it is taken at a clock
//   edge where busy is low. Command 0 offers a route (advertised_hops + 1,
//   saturating) from in_source_node; command 1 looks up in_destination.
//   Each command gives exactly one result word: out_valid is high for one
//   cycle with out_status, out_gateway and out_metric. The receiver
//   cannot stall; results are never held.
//   A command on own_address answers in the cycle after acceptance.
//   Otherwise the store is scanned from position 0 through one memory read
//   port, one entry per cycle, overlapped with the compare of the previous
//   entry; a hit ends the scan, a miss answers after every used entry.
//   busy is high during the scan, so one command runs at a time.
//   Reset empties the table and clears own_address; no clearing pass.
//   cfg_write_en writes own_address; write it only while busy is low.
// ----------------------------------------------------------------------------
module distance_vector_route_table
  import dvrt_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_command,
  input  logic [7:0] in_destination,
  input  logic [7:0] in_source_node,
  input  logic [7:0] in_advertised_hops,
  output logic       out_valid,
  output logic [2:0] out_status,
  output logic [7:0] out_gateway,
  output logic [7:0] out_metric,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_DEPTH);

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_t;

  state_t          state_r;
  logic [7:0]      own_r;
  logic [CW-1:0]   used_r;
  logic [CW-1:0]   scan_r;
  logic            pend_r;
  logic [AW-1:0]   cmp_idx_r;
  logic            cmd_r;
  logic [7:0]      dest_r;
  logic [7:0]      src_r;
  logic [7:0]      offered_r;
  logic            out_valid_r;
  status_t         out_status_r;
  logic [7:0]      out_gateway_r;
  logic [7:0]      out_metric_r;

  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  entry_t          wr_entry;
  entry_t          rd_entry;
  logic            issue;
  logic            hit;
  logic [7:0]      offered_in;

  dvrt_store #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (scan_r[AW-1:0]),
    .rd_entry (rd_entry)
  );

  assign issue = (scan_r < used_r);
  assign hit   = pend_r && (rd_entry.destination == dest_r);
  assign offered_in = (in_advertised_hops == HOPS_MAX) ? HOPS_MAX
                                                       : in_advertised_hops + 8'd1;

  // write port: improve a matched entry or append at the end
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = cmp_idx_r;
    wr_entry = '{destination: dest_r, gateway: src_r, hops: offered_r};
    if (state_r == S_SEARCH && !cmd_r) begin
      if (hit) begin
        wr_en = (offered_r < rd_entry.hops);
      end else if (!issue && used_r != FULL_COUNT) begin
        wr_en   = 1'b1;
        wr_addr = used_r[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      own_r       <= '0;
      used_r      <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_write_en) begin
        own_r <= cfg_write_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r     <= in_command;
            dest_r    <= in_destination;
            src_r     <= in_source_node;
            offered_r <= offered_in;
            if (in_destination == own_r) begin
              out_valid_r   <= 1'b1;
              out_status_r  <= in_command ? ST_SELF : ST_OWN;
              out_gateway_r <= '0;
              out_metric_r  <= '0;
            end else begin
              scan_r  <= '0;
              pend_r  <= 1'b0;
              state_r <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (hit) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (cmd_r) begin
              out_status_r  <= ST_FOUND;
              out_gateway_r <= rd_entry.gateway;
              out_metric_r  <= rd_entry.hops;
            end else if (offered_r < rd_entry.hops) begin
              out_status_r  <= ST_IMPROVED;
              out_gateway_r <= src_r;
              out_metric_r  <= offered_r;
            end else begin
              out_status_r  <= ST_UNCHANGED;
              out_gateway_r <= rd_entry.gateway;
              out_metric_r  <= rd_entry.hops;
            end
          end else if (issue) begin
            // read next entry, compare it next cycle
            pend_r    <= 1'b1;
            cmp_idx_r <= scan_r[AW-1:0];
            scan_r    <= scan_r + CW'(1);
          end else begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            pend_r      <= 1'b0;
            if (cmd_r) begin
              out_status_r  <= ST_NO_ROUTE;
              out_gateway_r <= '0;
              out_metric_r  <= '0;
            end else if (used_r == FULL_COUNT) begin
              out_status_r  <= ST_FULL;
              out_gateway_r <= '0;
              out_metric_r  <= '0;
            end else begin
              out_status_r  <= ST_INSERTED;
              out_gateway_r <= src_r;
              out_metric_r  <= offered_r;
              used_r        <= used_r + CW'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_gateway = out_gateway_r;
  assign out_metric  = out_metric_r;

endmodule

// ----- verif/distance_vector_route_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// distance_vector_route_table_tb: self-checking bench for the route table
// Drives advertisement and lookup words, predicts every answer from a local
// copy of the table and own address, and checks each result word in order.
// ----------------------------------------------------------------------------
module distance_vector_route_table_tb;
  import dvrt_pkg::*;

  localparam int TableDepth = 16;
  localparam int CycleLimit = 400000;
  localparam logic CMD_ADVERTISE = 1'b0;
  localparam logic CMD_LOOKUP    = 1'b1;

  typedef struct {
    logic       command;
    logic [7:0] destination;
    logic [7:0] source_node;
    logic [7:0] advertised_hops;
  } route_word_t;

  typedef struct {
    status_t    status;
    logic [7:0] gateway;
    logic [7:0] metric;
  } route_answer_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_command;
  logic [7:0] in_destination;
  logic [7:0] in_source_node;
  logic [7:0] in_advertised_hops;
  logic       out_valid;
  logic [2:0] out_status;
  logic [7:0] out_gateway;
  logic [7:0] out_metric;
  logic       cfg_write_en;
  logic [7:0] cfg_write_data;

  route_word_t   command_words[$];
  route_answer_t pending_answers[$];
  route_word_t   offered_word;
  bit            no_idle;
  int            mismatch_count;
  int            cycle_count;

  // local copy of the table
  logic [7:0] own_addr_copy;
  logic [7:0] route_dest[TableDepth];
  logic [7:0] route_next[TableDepth];
  logic [7:0] route_hops[TableDepth];
  int         routes_used;

  distance_vector_route_table #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_destination    (in_destination),
    .in_source_node    (in_source_node),
    .in_advertised_hops(in_advertised_hops),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_gateway       (out_gateway),
    .out_metric        (out_metric),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data)
  );

  always #5 clk = ~clk;

  function automatic route_answer_t route_answer(route_word_t w);
    route_answer_t r;
    int pos;
    logic [7:0] offered;
    r = '{ST_OWN, 8'd0, 8'd0};
    pos = -1;
    for (int i = 0; i < routes_used; i++) begin
      if (pos < 0 && route_dest[i] == w.destination) pos = i;
    end
    offered = (w.advertised_hops == HOPS_MAX) ? HOPS_MAX : w.advertised_hops + 8'd1;
    if (w.destination == own_addr_copy) begin
      r.status = (w.command == CMD_LOOKUP) ? ST_SELF : ST_OWN;
    end else if (w.command == CMD_LOOKUP) begin
      if (pos < 0) r.status = ST_NO_ROUTE;
      else r = '{ST_FOUND, route_next[pos], route_hops[pos]};
    end else if (pos >= 0) begin
      if (offered < route_hops[pos]) begin
        route_next[pos] = w.source_node;
        route_hops[pos] = offered;
        r = '{ST_IMPROVED, w.source_node, offered};
      end else begin
        r = '{ST_UNCHANGED, route_next[pos], route_hops[pos]};
      end
    end else if (routes_used >= TableDepth) begin
      r.status = ST_FULL;
    end else begin
      route_dest[routes_used] = w.destination;
      route_next[routes_used] = w.source_node;
      route_hops[routes_used] = offered;
      routes_used++;
      r = '{ST_INSERTED, w.source_node, offered};
    end
    return r;
  endfunction

  // driver: hold a word until taken, otherwise idle now and then
  always @(posedge clk) begin
    route_word_t w;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) pending_answers.push_back(route_answer(offered_word));
      if (start && busy) begin
        // hold the current word
      end else if (command_words.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
        w = command_words.pop_front();
        offered_word = w;
        in_command <= w.command;
        in_destination <= w.destination;
        in_source_node <= w.source_node;
        in_advertised_hops <= w.advertised_hops;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    route_answer_t want;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual status=%0d gateway=%0d hops=%0d",
                 $time, out_status, out_gateway, out_metric);
        mismatch_count++;
      end else begin
        want = pending_answers.pop_front();
        if (out_status !== want.status || out_gateway !== want.gateway ||
            out_metric !== want.metric) begin
          $display("%0t: mismatch: expected status=%0d gateway=%0d hops=%0d, %s",
                   $time, want.status, want.gateway, want.metric,
                   $sformatf("actual status=%0d gateway=%0d hops=%0d",
                             out_status, out_gateway, out_metric));
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d words queued, %0d answers pending",
               $time, command_words.size(), pending_answers.size());
      $display("distance_vector_route_table_tb: FAIL");
      $finish;
    end
  end

  task automatic queue_word(input logic cmd, input logic [7:0] dest, input logic [7:0] src,
                            input logic [7:0] hops);
    route_word_t w;
    w = '{cmd, dest, src, hops};
    command_words.push_back(w);
  endtask

  task automatic queue_random_words(input int count);
    route_word_t w;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      w.command = 1'($urandom_range(1, 0));
      if (sel < 65 && routes_used > 0) w.destination = route_dest[$urandom_range(routes_used - 1)];
      else if (sel < 75) w.destination = own_addr_copy;
      else w.destination = 8'($urandom_range(255));
      w.source_node = 8'($urandom_range(255));
      w.advertised_hops = ($urandom_range(9) == 0) ? HOPS_MAX : 8'($urandom_range(255));
      command_words.push_back(w);
    end
  endtask

  // wait until every word is answered and the block is idle
  task automatic drain;
    while (command_words.size() != 0 || start || pending_answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_own_address(input logic [7:0] addr);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= addr;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    own_addr_copy = addr;
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_command = 1'b0;
    in_destination = 8'd0;
    in_source_node = 8'd0;
    in_advertised_hops = 8'd0;
    cfg_write_en = 1'b0;
    cfg_write_data = 8'd0;
    no_idle = 1'b0;
    mismatch_count = 0;
    cycle_count = 0;
    own_addr_copy = 8'd0;
    routes_used = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // own address still at its reset value
    queue_word(CMD_LOOKUP, 8'd0, 8'd0, 8'd0);
    queue_word(CMD_ADVERTISE, 8'd0, 8'd9, 8'd3);
    queue_word(CMD_LOOKUP, 8'd200, 8'd0, 8'd0);
    queue_word(CMD_ADVERTISE, 8'd255, 8'd0, 8'd255);
    queue_word(CMD_ADVERTISE, 8'd255, 8'd255, 8'd254);
    queue_word(CMD_ADVERTISE, 8'd255, 8'd17, 8'd253);
    queue_word(CMD_LOOKUP, 8'd255, 8'd255, 8'd255);
    for (int d = 1; d <= 14; d++) begin
      queue_word(CMD_ADVERTISE, 8'(d), 8'(8'hA0 + d), (d == 1) ? 8'd0 : 8'd250);
    end
    drain();
    write_own_address(8'd255);
    // a stored route now names this node
    queue_word(CMD_LOOKUP, 8'd255, 8'd0, 8'd0);
    queue_word(CMD_ADVERTISE, 8'd255, 8'd3, 8'd1);
    queue_word(CMD_ADVERTISE, 8'd0, 8'd1, 8'd100);
    queue_word(CMD_ADVERTISE, 8'd200, 8'd2, 8'd5);
    queue_word(CMD_LOOKUP, 8'd0, 8'd0, 8'd0);
    queue_word(CMD_ADVERTISE, 8'd3, 8'd4, 8'd0);
    drain();

    write_own_address(8'd0);
    queue_random_words(300);
    drain();
    write_own_address(8'd255);
    queue_random_words(300);
    drain();
    write_own_address(route_dest[$urandom_range(routes_used - 1)]);
    no_idle = 1'b1;
    queue_random_words(300);
    drain();
    no_idle = 1'b0;
    write_own_address(8'($urandom_range(255)));
    queue_random_words(300);
    drain();
    write_own_address(8'h80);
    queue_random_words(300);
    drain();

    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("distance_vector_route_table_tb: PASS");
    end else begin
      $display("distance_vector_route_table_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/dvrt_pkg.sv
src/dvrt_store.sv
src/distance_vector_route_table.sv
verif/distance_vector_route_table_tb.sv
